FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Field widths, request and status codes, and the controller command bundle
// shared by the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default configuration
  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_DATA_WIDTH = 32;

  // Fixed channel field widths
  localparam int REQ_W      = 2;
  localparam int DATA_IN_W  = 32;
  localparam int DATA_OUT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_type_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // request transfer this cycle
    logic load;     // move pending result into the output register
  } deq_cmd_t;

endpackage

FILE: sv/deq_if.sv
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready request and response channels of the double-ended queue.
// ----------------------------------------------------------------------------

// Request channel
interface deq_req_if import deq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  req_type_t            req_type;
  logic [DATA_IN_W-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

// Response channel
interface deq_rsp_if import deq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_OUT_W-1:0] data_out;
  status_t               status;
  logic [FILL_W-1:0]     fill_level;

  modport source (output valid, output data_out, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input data_out, input status, input fill_level,
                  output ready);
endinterface

FILE: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences each request: transfer in, the registered store access, then
// hand the result to the output register when it is free.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;
  logic   accept;

  // Output slot is free when empty or being drained this cycle
  assign load     = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || load;
  assign accept   = in_valid && in_ready;

  assign cmd.accept = accept;
  assign cmd.load   = load;
  assign out_valid  = out_valid_r;

  // Next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      state_nxt     = S_IDLE;
    end
    if (accept) begin
      state_nxt = S_RESULT;
    end
  end

  // State and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/deq_datapath.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Circular word store with front index and fill count, status decode,
// pending result and output register.
// ----------------------------------------------------------------------------
module deq_datapath import deq_pkg::*; #(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  deq_cmd_t              cmd,
  input  req_type_t             req_type,
  input  logic [DATA_IN_W-1:0]  data_in,
  output logic [DATA_OUT_W-1:0] data_out,
  output status_t               status,
  output logic [FILL_W-1:0]     fill_level
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = IDX_W + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Fold a position below twice the depth back into the store
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] pos);
    if (pos >= DEPTH_S) begin
      return IDX_W'(pos - DEPTH_S);
    end
    return IDX_W'(pos);
  endfunction

  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  pend_pop_r;
  status_t               pend_status_r;
  logic [FILL_W-1:0]     pend_fill_r;
  logic [DATA_OUT_W-1:0] out_data_r;
  status_t               out_status_r;
  logic [FILL_W-1:0]     out_fill_r;

  logic [SUM_W-1:0]      tail_sum, last_sum;
  logic [IDX_W-1:0]      tail_idx, last_idx, front_dec, front_inc;
  logic                  full, empty;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  status_t               status_nxt;
  logic [DATA_WIDTH-1:0] wdata;

  // Index arithmetic
  assign tail_sum  = {1'b0, front_r} + SUM_W'(count_r);
  assign last_sum  = tail_sum - SUM_W'(1);
  assign tail_idx  = wrap_idx(tail_sum);
  assign last_idx  = wrap_idx(last_sum);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - IDX_W'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + IDX_W'(1);
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign wdata     = DATA_WIDTH'(data_in);

  // Request decode
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    rd_en      = 1'b0;
    rd_addr    = front_r;
    status_nxt = ST_OK;
    case (req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = front_dec;
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = tail_idx;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = front_r;
          front_nxt = front_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last_idx;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Front index and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Word store, registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem_r[wr_addr] <= wdata;
    end
    if (cmd.accept && rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Pending result, captured at request transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_pop_r    <= rd_en;
      pend_status_r <= status_nxt;
      pend_fill_r   <= FILL_W'(count_nxt);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r   <= pend_pop_r ? DATA_OUT_W'(rd_data_r) : '0;
      out_status_r <= pend_status_r;
      out_fill_r   <= pend_fill_r;
    end
  end

  assign data_out   = out_data_r;
  assign status     = out_status_r;
  assign fill_level = out_fill_r;

endmodule

FILE: sv/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Ring-buffer deque: push or pop a word at either end, one response per
// request carrying the popped word, a status and the new fill level.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : valid/ready request channel (req_type, data_in).
//   out_rsp : valid/ready response channel (data_out, status, fill_level).
//   Every request produces exactly one response, in order. A pop from an
//   empty queue returns status ST_EMPTY, a push to a full queue returns
//   ST_FULL and drops the word; neither changes the contents.
//   Response timing: with the output register free, the response is valid
//   from the clock edge after the request transfer; the store read is
//   registered at the transfer and the output register is loaded from it.
//   Throughput: one request per cycle while responses are taken; the
//   request and the output load overlap, bounded by the single store port.
//   Back-pressure: a stalled response holds the output register; one more
//   request is taken and held pending, then in_req.ready stays low until
//   out_rsp is drained.
//   Reset (synchronous, active low) empties the queue: front index and fill
//   count go to zero. The store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input logic         clk,
  input logic         rst_n,
  deq_req_if.sink     in_req,
  deq_rsp_if.source   out_rsp
);

  deq_cmd_t cmd;

  // Sequencing
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // Store, indices and result registers
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_type   (in_req.req_type),
    .data_in    (in_req.data_in),
    .data_out   (out_rsp.data_out),
    .status     (out_rsp.status),
    .fill_level (out_rsp.fill_level)
  );

  // A full-queue rejection reports the full level
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status == ST_FULL) |->
      (out_rsp.fill_level == FILL_W'(DEPTH)))
    else $error("push rejection with fill level other than full");

  // An empty-queue rejection reports zero level and zero data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status == ST_EMPTY) |->
      (out_rsp.fill_level == '0) && (out_rsp.data_out == '0))
    else $error("pop rejection with non-zero level or data");

  // A fresh response must trace back to a request transfer through the result state and the output load
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(cmd.accept, 2))
    else $error("response raised without a request two cycles earlier");

  // Never load a result while a stalled one is still held
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_rsp.valid && !out_rsp.ready))
    else $error("output register overwritten under back-pressure");

endmodule

FILE: tb/deque_response_checker.sv
// ----------------------------------------------------------------------------
// Deque response checker
// Watches the request and response channels of the double-ended queue core,
// keeps its own ring-buffer deque in step with every accepted request and
// compares each accepted response, field by field, with the oldest predicted
// one. Mismatches and unexpected responses are counted for the top level.
// ----------------------------------------------------------------------------
module deque_response_checker import deq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  deq_req_if   req_mon,
  deq_rsp_if   rsp_mon,
  output int   error_count,
  output int   awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_OUT_W-1:0] data_out;
    status_t               status;
    logic [FILL_W-1:0]     fill_level;
  } deq_result_t;

  // Shadow deque state
  logic [DEQ_DATA_WIDTH-1:0] shadow_store [DEQ_DEPTH];
  int                        shadow_front;
  int                        shadow_fill;

  // Responses still owed by the core, oldest first
  deq_result_t awaited_rsp_q[$];
  int          mismatches;

  // Print one line per fault and count it
  task automatic log_mismatch(input string msg);
    $display("%0t ns: deque mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one request to the shadow deque and return the response it should give
  function automatic deq_result_t apply_request(input req_type_t rt,
                                                input logic [DATA_IN_W-1:0] word);
    deq_result_t res;
    int          pos;
    res = '{data_out: '0, status: ST_OK, fill_level: '0};
    case (rt)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_fill >= DEQ_DEPTH) begin
          res.status = ST_FULL;
        end else if (rt == REQ_PUSH_FRONT) begin
          shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
          shadow_store[shadow_front] = word[DEQ_DATA_WIDTH-1:0];
          shadow_fill++;
        end else begin
          pos = (shadow_front + shadow_fill) % DEQ_DEPTH;
          shadow_store[pos] = word[DEQ_DATA_WIDTH-1:0];
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (rt == REQ_POP_FRONT) begin
          res.data_out = DATA_OUT_W'(shadow_store[shadow_front]);
          shadow_front = (shadow_front + 1) % DEQ_DEPTH;
          shadow_fill--;
        end else begin
          pos = (shadow_front + shadow_fill - 1) % DEQ_DEPTH;
          res.data_out = DATA_OUT_W'(shadow_store[pos]);
          shadow_fill--;
        end
      end
    endcase
    res.fill_level = FILL_W'(shadow_fill);
    return res;
  endfunction

  // Sample both channels on the rising edge: requests first, then responses
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst_n) begin
      shadow_front = 0;
      shadow_fill  = 0;
      awaited_rsp_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        awaited_rsp_q.push_back(apply_request(req_mon.req_type, req_mon.data_in));

      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          log_mismatch($sformatf("response with nothing awaited (data %h status %0d fill %0d)",
                                 rsp_mon.data_out, rsp_mon.status, rsp_mon.fill_level));
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_mon.data_out !== want.data_out)
            log_mismatch($sformatf("data_out %h, expected %h",
                                   rsp_mon.data_out, want.data_out));
          if (rsp_mon.status !== want.status)
            log_mismatch($sformatf("status %0d, expected %0d",
                                   rsp_mon.status, want.status));
          if (rsp_mon.fill_level !== want.fill_level)
            log_mismatch($sformatf("fill_level %0d, expected %0d",
                                   rsp_mon.fill_level, want.fill_level));
        end
      end
    end
    error_count   <= mismatches;
    awaited_count <= awaited_rsp_q.size();
  end

endmodule

FILE: tb/double_ended_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives pushes and pops at both ends of the deque, first a directed run
// through empty, full and index wrap, then random phases biased towards
// filling, draining or holding level, with random idling on both channels.
// The response checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb import deq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1800;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count;
  int   awaited_count;
  bit   rsp_calm;

  deq_req_if in_req ();
  deq_rsp_if out_rsp ();

  double_ended_queue_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  deque_response_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_req),
    .rsp_mon       (out_rsp),
    .error_count   (error_count),
    .awaited_count (awaited_count)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Data word: mostly random, sometimes a corner pattern
  function automatic logic [DATA_IN_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 32'hAAAA_AAAA;
      3:       return 32'h5555_5555;
      4:       return 32'h8000_0001;
      default: return $urandom();
    endcase
  endfunction

  // One request transfer, after an optional idle stretch
  task automatic send_req(input req_type_t rt, input logic [DATA_IN_W-1:0] word,
                          input int gap);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.req_type <= rt;
    in_req.data_in  <= word;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Response side: random stalls, with calm stretches of full throughput
  initial begin
    int hold;
    int cyc;
    hold     = 0;
    cyc      = 0;
    rsp_calm = 1'b0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      if (hold > 0) begin
        hold--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
        if (!rsp_calm && $urandom_range(0, 3) == 0) hold = idle_len(1'b0);
      end
    end
  end

  // Reset, stimulus and verdict
  initial begin
    int        sent;
    int        phase_len;
    int        push_pct;
    bit        calm;
    req_type_t rt;
    rst_n           <= 1'b0;
    in_req.valid    <= 1'b0;
    in_req.req_type <= REQ_PUSH_FRONT;
    in_req.data_in  <= '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: pops from empty at both ends
    send_req(REQ_POP_FRONT, '1, 0);
    send_req(REQ_POP_BACK, 32'h1234_5678, 1);
    // Fill to full, front pushes wrap the front index below zero
    send_req(REQ_PUSH_FRONT, '0, 0);
    send_req(REQ_PUSH_BACK, '1, 0);
    send_req(REQ_PUSH_FRONT, 32'hAAAA_AAAA, 0);
    send_req(REQ_PUSH_BACK, 32'h5555_5555, 2);
    for (int i = 0; i < 12; i++)
      send_req((i % 3 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom(), 0);
    // Pushes to a full deque are dropped
    send_req(REQ_PUSH_FRONT, 32'hDEAD_BEEF, 0);
    send_req(REQ_PUSH_BACK, 32'hFFFF_0000, 0);
    // Pops at both ends
    send_req(REQ_POP_FRONT, '0, 0);
    send_req(REQ_POP_BACK, '0, 3);
    send_req(REQ_POP_FRONT, '0, 0);

    // Random phases: fill-heavy, drain-heavy or balanced
    sent = 0;
    while (sent < RANDOM_REQS) begin
      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && sent < RANDOM_REQS; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          rt = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
          rt = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        send_req(rt, pick_word(), idle_len(calm));
        sent++;
      end
    end
    in_req.valid <= 1'b0;

    // Drain, then allow for the response latency
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && awaited_count == 0) begin
      $display("double_ended_queue_core_tb: done, clean");
    end else begin
      $display("double_ended_queue_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("double_ended_queue_core_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ctrl.sv
sv/deq_datapath.sv
sv/double_ended_queue_core.sv
tb/deque_response_checker.sv
tb/double_ended_queue_core_tb.sv
